// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants for the skew matrix exponential
// Fixed widths of the term and sum words, the product and divider
// units, and the configuration register indexes.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int IN_FRAC   = 28;             // fraction bits of K entries
  localparam int OUT_FRAC  = 30;             // fraction bits of results
  localparam int DATA_W    = 32;
  localparam int VAL_W     = 62;             // signed term / sum word
  localparam int MAG_W     = VAL_W - 1;      // magnitude of a term word
  localparam logic [MAG_W-1:0] LIM = '1;     // 2^61 - 1
  localparam int PROD_W    = MAG_W + DATA_W; // full product magnitude
  localparam int DVD_W     = 64;             // divider word
  localparam int DIV_STEP  = 8;              // quotient bits per cycle
  localparam int MAXT_W    = 6;
  localparam int THR_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TERMS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 2'd1;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  a_mag;
    logic [DATA_W-1:0] b_mag;
  } mul_req_t;

  function automatic logic [MAG_W-1:0] val_mag(input val_t v);
    logic [VAL_W-1:0] n;
    n = v[VAL_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/sme_if.sv =====
// ----------------------------------------------------------------------------
// sme_if: channel interfaces of the skew matrix exponential
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface sme_in_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] skew_a01;
  logic signed [DATA_W-1:0] skew_a02;
  logic signed [DATA_W-1:0] skew_a12;

  modport source (output valid, skew_a01, skew_a02, skew_a12, input ready);
  modport sink   (input valid, skew_a01, skew_a02, skew_a12, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] exp_r00;
  logic signed [DATA_W-1:0] exp_r01;
  logic signed [DATA_W-1:0] exp_r02;
  logic signed [DATA_W-1:0] exp_r10;
  logic signed [DATA_W-1:0] exp_r11;
  logic signed [DATA_W-1:0] exp_r12;
  logic signed [DATA_W-1:0] exp_r20;
  logic signed [DATA_W-1:0] exp_r21;
  logic signed [DATA_W-1:0] exp_r22;
  logic                     converged;
  logic [MAXT_W-1:0]        terms_used;

  modport source (output valid, exp_r00, exp_r01, exp_r02, exp_r10, exp_r11, exp_r12,
                  exp_r20, exp_r21, exp_r22, converged, terms_used, input ready);
  modport sink   (input valid, exp_r00, exp_r01, exp_r02, exp_r10, exp_r11, exp_r12,
                  exp_r20, exp_r21, exp_r22, converged, terms_used, output ready);
endinterface

interface sme_cfg_if import sme_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sme_mul.sv =====
// ----------------------------------------------------------------------------
// sme_mul: shared product unit
// Magnitude of term entry times K entry, in two 32x32 partial products,
// then rounded half up by 2^28 and clamped to 2^61 - 1.
// ----------------------------------------------------------------------------
module sme_mul import sme_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mul_req_t         req,
  output logic             done,
  output logic [MAG_W-1:0] r_mag
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LO   = 3'd1;
  localparam logic [2:0] PH_HI   = 3'd2;
  localparam logic [2:0] PH_ADD  = 3'd3;
  localparam logic [2:0] PH_RND  = 3'd4;

  logic [2:0]          ph;
  logic [MAG_W-1:0]    a;
  logic [DATA_W-1:0]   b;
  logic [DATA_W-1:0]   op;
  logic [2*DATA_W-1:0] pp;
  logic [2*DATA_W-1:0] prod_w;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W:0]     rnd;
  logic [PROD_W:0]     shd;

  assign op     = (ph == PH_LO) ? a[DATA_W-1:0] : DATA_W'(a[MAG_W-1:DATA_W]);
  assign prod_w = op * b;
  assign rnd    = {1'b0, acc} + ((PROD_W+1)'(1) << (IN_FRAC - 1));
  assign shd    = rnd >> IN_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        PH_IDLE: begin
          if (req.start) begin
            a  <= req.a_mag;
            b  <= req.b_mag;
            ph <= PH_LO;
          end
        end
        PH_LO: begin
          pp <= prod_w;
          ph <= PH_HI;
        end
        PH_HI: begin
          acc <= PROD_W'(pp);
          pp  <= prod_w;
          ph  <= PH_ADD;
        end
        PH_ADD: begin
          acc <= acc + (PROD_W'(pp) << DATA_W);
          ph  <= PH_RND;
        end
        PH_RND: begin
          r_mag <= (shd > (PROD_W+1)'(LIM)) ? LIM : shd[MAG_W-1:0];
          done  <= 1'b1;
          ph    <= PH_IDLE;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sme_div.sv =====
// ----------------------------------------------------------------------------
// sme_div: iterative divider by the step number
// Restoring division, DIV_STEP quotient bits per cycle on a narrow
// remainder.
// ----------------------------------------------------------------------------
module sme_div import sme_pkg::*; #(
  parameter int DIVISOR_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DVD_W-1:0]     quotient
);

  localparam int ROUNDS = DVD_W / DIV_STEP;
  localparam int CNT_W  = $clog2(ROUNDS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DVD_W-1:0]     w;
  logic [DIVISOR_W-1:0] r;
  logic [DIVISOR_W-1:0] d;
  logic [DVD_W-1:0]     w_next;
  logic [DIVISOR_W-1:0] r_next;

  always_comb begin
    logic [DIVISOR_W:0] t;
    w_next = w;
    r_next = r;
    for (int s = 0; s < DIV_STEP; s++) begin
      t      = {r_next, w_next[DVD_W-1]};
      w_next = {w_next[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t         = t - {1'b0, d};
        w_next[0] = 1'b1;
      end
      r_next = t[DIVISOR_W-1:0];
    end
  end

  assign quotient = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        w    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        w   <= w_next;
        r   <= r_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/skew_matrix_exponential.sv =====
// ----------------------------------------------------------------------------
// skew_matrix_exponential: exp(K) of a 3x3 skew-symmetric matrix
// Taylor series under a small sequencer sharing one product unit and one
// divider.
// ----------------------------------------------------------------------------
// Usage:
//   src : one transfer carries a01, a02, a12 (Q3.28) of
//         K = [[0,a01,a02],[-a01,0,a12],[-a02,-a12,0]].
//   res : one transfer carries exp(K) row by row (Q1.30, saturated), the
//         converged flag and the number of series terms added.
//   cfg : register writes (max_terms, stop_threshold), always ready; write
//         only while no item is in flight.
// Each series term needs 9 entries x (3 products on the shared two-pass
// 32x32 multiplier + one division in the 8-bit-per-cycle divider), and then
// the ST_STEP state closes the term. src is not ready while an item is
// worked on.
// The finished result sits in an output register; src takes the next item
// while it waits. If the receiver stalls, the next item finishes and then
// holds until the output register frees.
// Reset (synchronous) empties the output register, returns to idle and
// sets max_terms to 50 and stop_threshold to 0.
// ----------------------------------------------------------------------------
module skew_matrix_exponential import sme_pkg::*; #(
  parameter int TERM_LIMIT    = 50,
  parameter int FRACTION_BITS = 28
) (
  input  logic     clk,
  input  logic     rst,
  sme_cfg_if.sink  cfg,
  sme_in_if.sink   src,
  sme_out_if.source res
);

  localparam int KW   = $clog2(TERM_LIMIT + 1);
  localparam int T_UP = (FRACTION_BITS >= IN_FRAC) ? FRACTION_BITS - IN_FRAC : 0;
  localparam int T_DN = (FRACTION_BITS < IN_FRAC) ? IN_FRAC - FRACTION_BITS : 0;
  localparam int O_UP = (FRACTION_BITS <= OUT_FRAC) ? OUT_FRAC - FRACTION_BITS : 0;
  localparam int O_DN = (FRACTION_BITS > OUT_FRAC) ? FRACTION_BITS - OUT_FRAC : 0;
  localparam val_t ONE = VAL_W'(1) << FRACTION_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  function automatic val_t sat_val(input logic signed [VAL_W:0] x);
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    hi = $signed({2'b00, LIM});
    lo = -hi;
    if (x > hi) return hi[VAL_W-1:0];
    if (x < lo) return lo[VAL_W-1:0];
    return x[VAL_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input val_t s);
    logic [63:0] m;
    logic [63:0] mn;
    m = 64'(val_mag(s));
    if (O_DN == 0) begin
      if (m > ((64'd1 << 32) >> O_UP)) m = 64'd1 << 32;
      else m = m << O_UP;
    end else begin
      m = (m + ((64'd1 << O_DN) >> 1)) >> O_DN;
      if (m > (64'd1 << 32)) m = 64'd1 << 32;
    end
    mn = -m;
    if (!s[VAL_W-1]) return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    return (m > 64'h8000_0000) ? 32'h8000_0000 : mn[31:0];
  endfunction

  // configuration
  logic [MAXT_W-1:0] max_terms;
  logic [THR_W-1:0]  stop_threshold;

  // item state
  logic [2:0]               state;
  logic signed [DATA_W-1:0] a01, a02, a12;
  logic [KW-1:0]            lim;
  logic [63:0]              thr;
  logic [KW-1:0]            k;
  logic [1:0]               i, j, l;
  val_t                     term [9];
  val_t                     nxt  [9];
  val_t                     sum  [9];
  logic signed [63:0]       acc;
  logic                     acc_neg;
  logic                     prod_neg;
  logic [MAG_W-1:0]         norm;

  // result register
  logic                     res_valid;
  logic [DATA_W-1:0]        ores [9];
  logic                     oconv;
  logic [MAXT_W-1:0]        oterms;

  logic [3:0]               idx_il, idx_ij;
  val_t                     term_sel;
  logic signed [DATA_W-1:0] kx;
  logic                     kflip;
  logic [DATA_W-1:0]        kmag;
  mul_req_t                 mreq;
  logic                     mul_done;
  logic [MAG_W-1:0]         mul_r;
  logic [63:0]              pm;
  logic [63:0]              am;
  logic [MAG_W-1:0]         mc;
  logic [DVD_W-1:0]         dvd;
  logic                     div_done;
  logic [DVD_W-1:0]         quot;
  logic [MAG_W-1:0]         q;
  val_t                     v;
  logic [6:0]               k_ext;
  logic                     out_free;

  assign idx_il   = 4'(i) * 4'd3 + 4'(l);
  assign idx_ij   = 4'(i) * 4'd3 + 4'(j);
  assign term_sel = term[idx_il];

  // K entry (l, j): stored value and whether it is negated
  always_comb begin
    kx    = '0;
    kflip = 1'b0;
    case ({l, j})
      4'b00_01: kx = a01;
      4'b00_10: kx = a02;
      4'b01_10: kx = a12;
      4'b01_00: begin kx = a01; kflip = 1'b1; end
      4'b10_00: begin kx = a02; kflip = 1'b1; end
      4'b10_01: begin kx = a12; kflip = 1'b1; end
      default:  kx = '0;
    endcase
  end

  assign kmag       = kx[DATA_W-1] ? -kx : kx;
  assign mreq.start = (state == ST_MUL);
  assign mreq.a_mag = val_mag(term_sel);
  assign mreq.b_mag = kmag;

  sme_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .done  (mul_done),
    .r_mag (mul_r)
  );

  assign pm  = {{(64-MAG_W){1'b0}}, mul_r};
  assign am  = acc[63] ? -acc : acc;
  assign mc  = (am > 64'(LIM)) ? LIM : am[MAG_W-1:0];
  assign dvd = 64'(mc) + 64'(k >> 1);

  sme_div #(.DIVISOR_W(KW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DSTART),
    .dividend (dvd),
    .divisor  (k),
    .done     (div_done),
    .quotient (quot)
  );

  assign q        = quot[MAG_W-1:0];
  assign v        = acc_neg ? -{1'b0, q} : {1'b0, q};
  assign k_ext    = 7'(k);
  assign out_free = !res_valid || res.ready;

  assign cfg.ready = 1'b1;
  assign src.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_terms      <= MAXT_W'(50);
      stop_threshold <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAX_TERMS:      max_terms      <= cfg.data[MAXT_W-1:0];
        REG_STOP_THRESHOLD: stop_threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (src.valid) begin
            a01 <= src.skew_a01;
            a02 <= src.skew_a02;
            a12 <= src.skew_a12;
            if (max_terms == '0) lim <= KW'(1);
            else if (int'(max_terms) > TERM_LIMIT) lim <= KW'(TERM_LIMIT);
            else lim <= KW'(max_terms);
            thr <= (64'(stop_threshold) << T_UP) >> T_DN;
            for (int n = 0; n < 9; n++) begin
              term[n] <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
              sum[n]  <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
            end
            k     <= KW'(1);
            i     <= '0;
            j     <= '0;
            l     <= '0;
            acc   <= '0;
            norm  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_neg <= term_sel[VAL_W-1] ^ kx[DATA_W-1] ^ kflip;
          state    <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            acc <= prod_neg ? acc - $signed(pm) : acc + $signed(pm);
            if (l == 2'd2) begin
              state <= ST_DSTART;
            end else begin
              l     <= l + 1'b1;
              state <= ST_MUL;
            end
          end
        end
        ST_DSTART: begin
          acc_neg <= acc[63];
          state   <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            nxt[idx_ij] <= v;
            sum[idx_ij] <= sat_val({sum[idx_ij][VAL_W-1], sum[idx_ij]} + {v[VAL_W-1], v});
            if (q > norm) norm <= q;
            l   <= '0;
            acc <= '0;
            if (i == 2'd2 && j == 2'd2) begin
              state <= ST_STEP;
            end else begin
              if (j == 2'd2) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
              state <= ST_MUL;
            end
          end
        end
        ST_STEP: begin
          for (int n = 0; n < 9; n++) term[n] <= nxt[n];
          if (k < lim && 64'(norm) > thr) begin
            k     <= k + 1'b1;
            norm  <= '0;
            i     <= '0;
            j     <= '0;
            state <= ST_MUL;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            for (int n = 0; n < 9; n++) ores[n] <= to_out(sum[n]);
            oconv  <= (64'(norm) <= thr);
            oterms <= k_ext[MAXT_W-1:0];
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign res.valid      = res_valid;
  assign res.exp_r00    = ores[0];
  assign res.exp_r01    = ores[1];
  assign res.exp_r02    = ores[2];
  assign res.exp_r10    = ores[3];
  assign res.exp_r11    = ores[4];
  assign res.exp_r12    = ores[5];
  assign res.exp_r20    = ores[6];
  assign res.exp_r21    = ores[7];
  assign res.exp_r22    = ores[8];
  assign res.converged  = oconv;
  assign res.terms_used = oterms;

endmodule

// ===== rtl/sme_checker.sv =====
// ----------------------------------------------------------------------------
// sme_checker: port-level checks on the skew matrix exponential
// Watches the input and result channels over time.
// ----------------------------------------------------------------------------
module sme_checker import sme_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              src_valid,
  input logic              src_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              converged,
  input logic [MAXT_W-1:0] terms_used
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(terms_used) && $stable(converged))
    else $error("stalled result changed");

  // at least one series term is always added
  a_terms_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> terms_used != '0)
    else $error("result with zero terms");

  // busy once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_ready |=> !src_ready)
    else $error("input ready right after a transfer");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && src_ready)
    else $error("bad state after reset");

endmodule

bind skew_matrix_exponential sme_checker u_sme_checker (
  .clk        (clk),
  .rst        (rst),
  .src_valid  (src.valid),
  .src_ready  (src.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .converged  (res.converged),
  .terms_used (res.terms_used)
);

// ===== tb/sme_exp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sme_exp_checker: result predictor and scoreboard for skew_matrix_exponential
// Follows register writes and input transfers, works out the series sum,
// the convergence flag and the step count of each item, and compares every
// result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sme_exp_checker import sme_pkg::*; #(
  parameter int TERM_LIMIT    = 50,
  parameter int FRACTION_BITS = 28
) (
  input  logic clk,
  input  logic rst,
  sme_cfg_if   cfg,
  sme_in_if    src,
  sme_out_if   res,
  output int   fail_count,
  output int   outstanding
);

  localparam longint VLIM = (64'sd1 <<< 61) - 1;

  typedef struct {
    logic [DATA_W-1:0] entry [9];
    logic              conv;
    logic [MAXT_W-1:0] steps;
  } exp_result_t;

  logic [MAXT_W-1:0] max_terms_q;
  logic [THR_W-1:0]  stop_thr_q;
  exp_result_t       exp_results [$];

  function automatic longint unsigned mag64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp61(input longint v);
    if (v > VLIM) return VLIM;
    if (v < -VLIM) return -VLIM;
    return v;
  endfunction

  // term entry times K entry, rounded back to the term scale
  function automatic longint mul_round(input longint t, input longint kv);
    logic [127:0] p;
    longint       r;
    p = 128'(mag64(t)) * 128'(mag64(kv));
    p = (p + (128'd1 << (IN_FRAC - 1))) >> IN_FRAC;
    r = (p > 128'(VLIM)) ? VLIM : longint'(p[63:0]);
    return ((t < 0) != (kv < 0)) ? -r : r;
  endfunction

  function automatic longint div_round(input longint v, input int k);
    longint unsigned m;
    m = (mag64(v) + k / 2) / k;
    if (m > VLIM) m = VLIM;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [DATA_W-1:0] to_q1_30(input longint s);
    longint unsigned m;
    longint          v;
    m = mag64(s);
    if (FRACTION_BITS <= OUT_FRAC) begin
      if (m > ((64'd1 << 32) >> (OUT_FRAC - FRACTION_BITS))) m = 64'd1 << 32;
      else m = m << (OUT_FRAC - FRACTION_BITS);
    end else begin
      m = (m + (64'd1 << (FRACTION_BITS - OUT_FRAC - 1))) >> (FRACTION_BITS - OUT_FRAC);
      if (m > (64'd1 << 32)) m = 64'd1 << 32;
    end
    v = s < 0 ? -longint'(m) : longint'(m);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[DATA_W-1:0];
  endfunction

  function automatic exp_result_t series_exp(input logic signed [DATA_W-1:0] a01,
                                             input logic signed [DATA_W-1:0] a02,
                                             input logic signed [DATA_W-1:0] a12);
    exp_result_t     r;
    longint          kmat [3][3];
    longint          term [3][3];
    longint          nxt  [3][3];
    longint          acc  [3][3];
    longint          accv;
    longint unsigned thr, norm;
    int              limit, k;
    limit = max_terms_q;
    if (limit == 0) limit = 1;
    if (limit > TERM_LIMIT) limit = TERM_LIMIT;
    if (FRACTION_BITS >= IN_FRAC) thr = 64'(stop_thr_q) << (FRACTION_BITS - IN_FRAC);
    else thr = 64'(stop_thr_q) >> (IN_FRAC - FRACTION_BITS);
    kmat = '{'{0, a01, a02}, '{-longint'(a01), 0, a12}, '{-longint'(a02), -longint'(a12), 0}};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        term[i][j] = (i == j) ? (64'sd1 <<< FRACTION_BITS) : 0;
        acc[i][j]  = term[i][j];
      end
    k = 0;
    do begin
      k++;
      norm = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          accv = 0;
          for (int l = 0; l < 3; l++) accv += mul_round(term[i][l], kmat[l][j]);
          nxt[i][j] = div_round(clamp61(accv), k);
          if (mag64(nxt[i][j]) > norm) norm = mag64(nxt[i][j]);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          term[i][j] = nxt[i][j];
          acc[i][j]  = clamp61(acc[i][j] + nxt[i][j]);
        end
    end while (k < limit && norm > thr);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r.entry[i*3+j] = to_q1_30(acc[i][j]);
    r.conv  = norm <= thr;
    r.steps = k[MAXT_W-1:0];
    return r;
  endfunction

  assign outstanding = exp_results.size();

  always @(posedge clk) begin
    exp_result_t want;
    logic [DATA_W-1:0] got [9];
    logic bad;
    if (rst) begin
      max_terms_q <= 6'd50;
      stop_thr_q  <= '0;
      fail_count  <= 0;
      exp_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MAX_TERMS) max_terms_q <= cfg.data[MAXT_W-1:0];
        else if (cfg.index == REG_STOP_THRESHOLD) stop_thr_q <= cfg.data[THR_W-1:0];
      end
      if (src.valid && src.ready)
        exp_results.push_back(series_exp(src.skew_a01, src.skew_a02, src.skew_a12));
      if (res.valid && res.ready) begin
        got = '{res.exp_r00, res.exp_r01, res.exp_r02, res.exp_r10, res.exp_r11,
                res.exp_r12, res.exp_r20, res.exp_r21, res.exp_r22};
        if (exp_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = exp_results.pop_front();
          bad = (want.conv !== res.converged) || (want.steps !== res.terms_used);
          for (int i = 0; i < 9; i++) if (want.entry[i] !== got[i]) bad = 1'b1;
          if (bad) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: expected entries %p conv %0d terms %0d",
                       $realtime, want.entry, want.conv, want.steps);
              $display("  actual entries %p conv %0d terms %0d",
                       got, res.converged, res.terms_used);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/skew_matrix_exponential_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skew_matrix_exponential_tb: top level test of skew_matrix_exponential
// Directed corner items, then phases of random items under several register
// settings, with random idling on both channels; checking is done in
// sme_exp_checker.
// ----------------------------------------------------------------------------
module skew_matrix_exponential_tb;
  import sme_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd120_000_000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   calm = 1'b0;
  int     fail_count, outstanding;
  longint cycles = 0;

  sme_cfg_if cfg ();
  sme_in_if  src ();
  sme_out_if res ();

  skew_matrix_exponential dut (.clk(clk), .rst(rst), .cfg(cfg), .src(src), .res(res));

  sme_exp_checker chk (.clk(clk), .rst(rst), .cfg(cfg), .src(src), .res(res),
                       .fail_count(fail_count), .outstanding(outstanding));

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("skew_matrix_exponential_tb NOT OK");
      $finish;
    end
  end

  initial res.ready = 1'b0;
  always @(negedge clk) res.ready <= calm || ($urandom_range(0, 99) >= 7);

  task automatic send_matrix(input logic [DATA_W-1:0] a01, input logic [DATA_W-1:0] a02,
                             input logic [DATA_W-1:0] a12);
    if (!calm && $urandom_range(0, 99) < 7) begin
      src.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    src.valid    = 1'b1;
    src.skew_a01 = a01;
    src.skew_a02 = a02;
    src.skew_a12 = a12;
    do @(posedge clk); while (!src.ready);
    @(negedge clk);
  endtask

  // holds off until the block has drained, then writes one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    src.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_entry(input int lo_shift, input int hi_shift);
    logic [DATA_W-1:0] v;
    v = $urandom >> $urandom_range(lo_shift, hi_shift);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic run_phase(input logic [DATA_W-1:0] mt, input logic [DATA_W-1:0] thr,
                           input int count, input int lo_shift, input int hi_shift);
    write_reg(REG_MAX_TERMS, mt);
    write_reg(REG_STOP_THRESHOLD, thr);
    for (int n = 0; n < count; n++) begin
      calm = (count >= 250) && (n >= 80) && (n < 200);
      send_matrix(rand_entry(lo_shift, hi_shift), rand_entry(lo_shift, hi_shift),
                  rand_entry(lo_shift, hi_shift));
    end
    calm = 1'b0;
  endtask

  localparam logic [DATA_W-1:0] ONE  = 32'h1000_0000;
  localparam logic [DATA_W-1:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MAXN = 32'h8000_0000;

  initial begin
    src.valid = 1'b0;
    src.skew_a01 = '0;
    src.skew_a02 = '0;
    src.skew_a12 = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: 50 steps, zero threshold
    send_matrix('0, '0, '0);
    send_matrix(ONE, '0, '0);
    send_matrix('0, -ONE, '0);
    send_matrix('0, '0, ONE);
    send_matrix(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_matrix(MAXP, MAXP, MAXP);
    send_matrix(MAXN, MAXN, MAXN);
    send_matrix(MAXP, MAXN, 32'h5555_5555);
    send_matrix(32'h0800_0000, 32'h0400_0000, 32'hF800_0000);
    // step limit of zero acts as one; unknown indexes are ignored
    write_reg(REG_MAX_TERMS, 32'hFFFF_FFC0);
    write_reg(2'd2, 32'h0000_0001);
    write_reg(2'd3, 32'hFFFF_FFFF);
    send_matrix(MAXN, MAXP, ONE);
    send_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);
    // limit above the parameter acts as the parameter
    write_reg(REG_MAX_TERMS, 32'h0000_003F);
    write_reg(REG_STOP_THRESHOLD, 32'h7FFF_FFFF);
    send_matrix(ONE, ONE, ONE);
    send_matrix(MAXP, MAXP, MAXN);
    write_reg(REG_STOP_THRESHOLD, 32'h0100_0000);
    send_matrix(32'h0200_0000, -32'sh0300_0000, 32'h0100_0000);
    send_matrix(ONE, '0, ONE);

    run_phase(32'hFFFF_FFC0, 32'h0000_0000, 250, 0, 10);
    run_phase(32'd2,         32'h7FFF_FFFF, 200, 0, 10);
    run_phase(32'd4,         $urandom,      250, 0, 10);
    run_phase(32'd6,         $urandom_range(0, 1 << 26), 250, 0, 10);
    run_phase(32'd50,        32'h0100_0000, 300, 4, 10);
    run_phase(32'hFFFF_FF3F, 32'h0010_0000, 250, 5, 12);
    run_phase(32'd50,        32'h0000_0000, 30, 8, 12);
    run_phase(32'd3,         $urandom,      200, 0, 12);

    src.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("skew_matrix_exponential_tb OK");
    end else begin
      $display("skew_matrix_exponential_tb NOT OK");
    end
    $finish;
  end

endmodule
